FILE: design/mnds_pkg.sv
// Shared types and constants for the maximum neighbour difference scan.
package mnds_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGLE   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          row_end;
    logic                          matrix_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value_here;
    logic signed [SAMPLE_BITS-1:0] value_neighbour;
    logic [1:0]                    status;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] here;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] up;
    logic [DIFF_BITS-1:0]          diff_left;
    logic [DIFF_BITS-1:0]          diff_up;
    logic                          use_left;
    logic                          use_up;
    logic                          matrix_end;
    logic [1:0]                    status;
  } work_item_t;

endpackage

FILE: design/mnds_front.sv
// Front end: accepts samples, tracks row geometry, reads the line buffer, forms differences.
module mnds_front import mnds_pkg::*; #(
  parameter int MAX_ROW_LENGTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  input  logic [QUEUE_LVL_W-1:0] q_level,
  output logic                   q_push,
  output work_item_t             q_item
);

  localparam int CW = $clog2(MAX_ROW_LENGTH + 1);
  localparam int AW = $clog2(MAX_ROW_LENGTH);

  logic [SAMPLE_BITS-1:0] line_mem [MAX_ROW_LENGTH];

  logic [CW-1:0]          col_r, col_nxt;
  logic [CW-1:0]          prev_len_r, prev_len_nxt;
  logic                   first_row_r, first_row_nxt;
  logic [SAMPLE_BITS-1:0] left_r, left_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                          a_v_r;
  logic signed [SAMPLE_BITS-1:0] a_s_r, a_left_r, a_up_r;
  logic                          a_use_left_r, a_use_up_r, a_end_r;
  logic [1:0]                    a_status_r;

  logic          accept, in_range, has_left, has_up;
  logic [CW-1:0] col_after;
  logic [1:0]    status;
  logic signed [DIFF_BITS-1:0] dl, du;

  assign in_stall = ({1'b0, q_level} + {{QUEUE_LVL_W{1'b0}}, a_v_r})
                    >= (QUEUE_LVL_W+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign in_range = col_r < CW'(MAX_ROW_LENGTH);
  assign has_left = col_r != '0;
  assign has_up   = in_range && !first_row_r && (col_r < prev_len_r);
  assign col_after = in_range ? col_r + CW'(1) : col_r;

  always_comb begin
    col_nxt       = col_after;
    prev_len_nxt  = prev_len_r;
    first_row_nxt = first_row_r;
    left_nxt      = in_item.sample_value;
    cnt_nxt       = (cnt_r == 2'd2) ? cnt_r : cnt_r + 2'd1;
    ovf_nxt       = ovf_r | !in_range;
    if (cnt_r == 2'd0) begin
      status = ST_SINGLE;
    end else if (ovf_nxt) begin
      status = ST_OVERFLOW;
    end else begin
      status = ST_OK;
    end
    if (in_item.row_end || in_item.matrix_end) begin
      prev_len_nxt  = col_after;
      col_nxt       = '0;
      first_row_nxt = 1'b0;
    end
    if (in_item.matrix_end) begin
      prev_len_nxt  = '0;
      first_row_nxt = 1'b1;
      left_nxt      = '0;
      cnt_nxt       = 2'd0;
      ovf_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      prev_len_r  <= '0;
      first_row_r <= 1'b1;
      left_r      <= '0;
      cnt_r       <= 2'd0;
      ovf_r       <= 1'b0;
      a_v_r       <= 1'b0;
    end else begin
      a_v_r <= accept;
      if (accept) begin
        col_r       <= col_nxt;
        prev_len_r  <= prev_len_nxt;
        first_row_r <= first_row_nxt;
        left_r      <= left_nxt;
        cnt_r       <= cnt_nxt;
        ovf_r       <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_up_r <= line_mem[col_r[AW-1:0]];
      if (in_range) begin
        line_mem[col_r[AW-1:0]] <= in_item.sample_value;
      end
      a_s_r        <= in_item.sample_value;
      a_left_r     <= left_r;
      a_use_left_r <= has_left;
      a_use_up_r   <= has_up;
      a_end_r      <= in_item.matrix_end;
      a_status_r   <= status;
    end
  end

  always_comb begin
    dl = {a_s_r[SAMPLE_BITS-1], a_s_r} - {a_left_r[SAMPLE_BITS-1], a_left_r};
    du = {a_s_r[SAMPLE_BITS-1], a_s_r} - {a_up_r[SAMPLE_BITS-1], a_up_r};
    q_item.here       = a_s_r;
    q_item.left       = a_left_r;
    q_item.up         = a_up_r;
    q_item.diff_left  = dl[DIFF_BITS-1] ? DIFF_BITS'(-dl) : DIFF_BITS'(dl);
    q_item.diff_up    = du[DIFF_BITS-1] ? DIFF_BITS'(-du) : DIFF_BITS'(du);
    q_item.use_left   = a_use_left_r;
    q_item.use_up     = a_use_up_r;
    q_item.matrix_end = a_end_r;
    q_item.status     = a_status_r;
  end

  assign q_push = a_v_r;

endmodule

FILE: design/mnds_queue.sv
// Short queue between the front end and the back end.
module mnds_queue import mnds_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  work_item_t             push_item,
  input  logic                   pop,
  output logic                   not_empty,
  output work_item_t             head,
  output logic [QUEUE_LVL_W-1:0] level
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  work_item_t              mem [QUEUE_DEPTH];
  logic [PW-1:0]           wr_r, rd_r;
  logic [QUEUE_LVL_W-1:0]  lvl_r;

  assign not_empty = lvl_r != '0;
  assign head      = mem[rd_r];
  assign level     = lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      lvl_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PW'(1);
      end
      if (push && !pop) begin
        lvl_r <= lvl_r + QUEUE_LVL_W'(1);
      end else if (pop && !push) begin
        lvl_r <= lvl_r - QUEUE_LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

endmodule

FILE: design/mnds_back.sv
// Back end: keeps the best pair and registers the result item at matrix end.
module mnds_back import mnds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  work_item_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic [DIFF_BITS-1:0]          best_diff_r;
  logic signed [SAMPLE_BITS-1:0] best_here_r, best_nb_r;
  logic                          out_valid_r;
  out_item_t                     out_r;

  logic                          upd_l, upd_u;
  logic [DIFF_BITS-1:0]          diff_l, diff_nxt;
  logic signed [SAMPLE_BITS-1:0] here_l, nb_l, here_nxt, nb_nxt;
  out_item_t                     res;

  assign q_pop = q_not_empty && (!q_head.matrix_end || !out_valid_r || !out_stall);

  always_comb begin
    upd_l    = q_head.use_left && (q_head.diff_left >= best_diff_r);
    diff_l   = upd_l ? q_head.diff_left : best_diff_r;
    here_l   = upd_l ? q_head.here : best_here_r;
    nb_l     = upd_l ? q_head.left : best_nb_r;
    upd_u    = q_head.use_up && (q_head.diff_up >= diff_l);
    diff_nxt = upd_u ? q_head.diff_up : diff_l;
    here_nxt = upd_u ? q_head.here : here_l;
    nb_nxt   = upd_u ? q_head.up : nb_l;
    res.status = q_head.status;
    if (q_head.status == ST_OK) begin
      res.value_here      = here_nxt;
      res.value_neighbour = nb_nxt;
    end else begin
      res.value_here      = '0;
      res.value_neighbour = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_diff_r <= '0;
      best_here_r <= '0;
      best_nb_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_head.matrix_end) begin
          best_diff_r <= '0;
          best_here_r <= '0;
          best_nb_r   <= '0;
        end else begin
          best_diff_r <= diff_nxt;
          best_here_r <= here_nxt;
          best_nb_r   <= nb_nxt;
        end
      end
      if (q_pop && q_head.matrix_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.matrix_end) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: design/max_neighbour_difference_scan_top.sv
// Top level of the maximum neighbour difference scan.
//
// Input channel (in_valid / in_stall / in_item): one grid sample per item in
// raster order, with row_end and matrix_end marks. Output channel (out_valid /
// out_stall / out_item): one result item per matrix, issued for the item that
// carries matrix_end, holding the winning (sample, neighbour) pair and status.
// An item is taken on a clock edge with valid high and stall low.
// Throughput: one item per cycle while in_stall is low, set by the single-port
// line buffer read at accept and the combinational back-end compare/select.
// A matrix-end item passes the front-end stage register and a queue entry;
// the back end then registers its result onto out_valid and out_item.
// A 4-entry queue separates the front end from the back end. While out_stall
// holds the result, later samples keep flowing until the queue reaches the
// next matrix end; in_stall rises when queue level plus a_v_r reaches depth.
// Reset (rst_n low, synchronous) clears the scan state, queue and output
// valid. The line buffer has no reset; entries are written before being used.
module max_neighbour_difference_scan_top import mnds_pkg::*; #(
  parameter int MAX_ROW_LENGTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic                   q_push, q_pop, q_not_empty;
  work_item_t             q_in, q_head;
  logic [QUEUE_LVL_W-1:0] q_level;

  mnds_front #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  mnds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .level     (q_level)
  );

  mnds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
